@@ rtl/char_stream_tokenizer_core_assert.svh @@
// Assertion shorthands used by the result queue RTL.
`ifndef CHAR_STREAM_TOKENIZER_CORE_ASSERT_SVH
`define CHAR_STREAM_TOKENIZER_CORE_ASSERT_SVH

// same-cycle implication
`define CST_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("tokenizer check failed");

// next-cycle implication
`define CST_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("tokenizer check failed");

`endif

@@ rtl/cst_pkg.sv @@
`default_nettype none

package cst_pkg;

   localparam int IDENT_BYTES_KEPT_DEFAULT = 8;
   localparam int RSP_DEPTH_DEFAULT        = 4;

   localparam logic [7:0]  CHAR_HASH = 8'h23;
   localparam logic [7:0]  CHAR_LF   = 8'h0A;
   localparam logic [7:0]  CHAR_CR   = 8'h0D;
   localparam logic [63:0] DEF_TEXT  = 64'h0000_0000_0066_6564;
   localparam logic [30:0] NUM_LIMIT = 31'h7FFF_FFFF;

   typedef enum logic [2:0] {
      TOKEN_END    = 3'd0,
      TOKEN_NUMBER = 3'd1,
      TOKEN_IDENT  = 3'd2,
      TOKEN_DEF    = 3'd3,
      TOKEN_CHAR   = 3'd4
   } token_kind_type;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_IDENT   = 2'd1,
      MODE_NUMBER  = 2'd2,
      MODE_COMMENT = 2'd3
   } mode_type;

   typedef struct packed {
      token_kind_type token_kind;
      logic [7:0]     char_value;
      logic [30:0]    number_value;
      logic           number_overflow;
      logic [63:0]    ident_text;
      logic [7:0]     ident_length;
      logic           ident_truncated;
      logic           last;
   } lex_token_type;

   // up to two tokens produced by one word
   typedef struct packed {
      logic [1:0]    count;
      lex_token_type first;
      lex_token_type second;
   } lex_out_type;

endpackage

`default_nettype wire

@@ rtl/cst_lexer.sv @@
`default_nettype none

module cst_lexer #(
   parameter int IDENT_BYTES_KEPT = cst_pkg::IDENT_BYTES_KEPT_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic [7:0]        char_code,
   input  wire logic              end_of_input,
   output cst_pkg::lex_out_type   lex_out
);
   import cst_pkg::*;

   localparam int TEXT_W = IDENT_BYTES_KEPT * 8;

   mode_type            mode_ff, mode_in;
   logic [TEXT_W-1:0]   ident_bytes_ff, ident_bytes_in;
   logic [7:0]          ident_count_ff, ident_count_in;
   logic [30:0]         number_accum_ff, number_accum_in;
   logic                number_sat_ff, number_sat_in;

   logic        is_space, is_alpha, is_digit;
   logic        ident_cont, number_cont;
   logic [34:0] num_wide;

   always_comb begin
      is_space    = (char_code == 8'h20) || (char_code >= 8'h09 && char_code <= 8'h0D);
      is_alpha    = (char_code >= 8'h41 && char_code <= 8'h5A) ||
                    (char_code >= 8'h61 && char_code <= 8'h7A);
      is_digit    = (char_code >= 8'h30 && char_code <= 8'h39);
      ident_cont  = (mode_ff == MODE_IDENT) && (is_alpha || is_digit);
      number_cont = (mode_ff == MODE_NUMBER) && is_digit;
      // accum * 10 + digit
      num_wide    = ({4'b0, number_accum_ff} << 3) + ({4'b0, number_accum_ff} << 1) +
                    35'(char_code[3:0]);
   end

   // next state
   always_comb begin
      mode_in         = mode_ff;
      ident_bytes_in  = ident_bytes_ff;
      ident_count_in  = ident_count_ff;
      number_accum_in = number_accum_ff;
      number_sat_in   = number_sat_ff;
      if (end_of_input) begin
         mode_in         = MODE_IDLE;
         ident_bytes_in  = '0;
         ident_count_in  = '0;
         number_accum_in = '0;
         number_sat_in   = 1'b0;
      end else if (mode_ff == MODE_COMMENT) begin
         if (char_code == CHAR_LF || char_code == CHAR_CR) begin
            mode_in = MODE_IDLE;
         end
      end else if (ident_cont) begin
         for (int i = 0; i < IDENT_BYTES_KEPT; i++) begin
            if (ident_count_ff == 8'(i)) begin
               ident_bytes_in[i*8 +: 8] = char_code;
            end
         end
         if (ident_count_ff != 8'hFF) begin
            ident_count_in = ident_count_ff + 8'd1;
         end
      end else if (number_cont) begin
         if (num_wide > 35'(NUM_LIMIT)) begin
            number_accum_in = NUM_LIMIT;
            number_sat_in   = 1'b1;
         end else begin
            number_accum_in = num_wide[30:0];
         end
      end else begin
         mode_in         = MODE_IDLE;
         ident_bytes_in  = '0;
         ident_count_in  = '0;
         number_accum_in = '0;
         number_sat_in   = 1'b0;
         if (is_space) begin
            mode_in = MODE_IDLE;
         end else if (is_alpha) begin
            mode_in        = MODE_IDENT;
            ident_bytes_in = TEXT_W'(char_code);
            ident_count_in = 8'd1;
         end else if (is_digit) begin
            mode_in         = MODE_NUMBER;
            number_accum_in = 31'(char_code[3:0]);
         end else if (char_code == CHAR_HASH) begin
            mode_in = MODE_COMMENT;
         end
      end
   end

   // outputs
   lex_token_type pend_tok, tail_tok;
   logic          pend_valid, pend_emit, tail_valid;

   always_comb begin
      pend_tok = '0;
      if (mode_ff == MODE_IDENT) begin
         pend_tok.token_kind = (ident_count_ff == 8'd3 && 64'(ident_bytes_ff) == DEF_TEXT) ?
                               TOKEN_DEF : TOKEN_IDENT;
         pend_tok.ident_text      = 64'(ident_bytes_ff);
         pend_tok.ident_length    = ident_count_ff;
         pend_tok.ident_truncated = ident_count_ff > 8'(IDENT_BYTES_KEPT);
      end else begin
         pend_tok.token_kind      = TOKEN_NUMBER;
         pend_tok.number_value    = number_accum_ff;
         pend_tok.number_overflow = number_sat_ff;
      end
      pend_valid = (mode_ff == MODE_IDENT) || (mode_ff == MODE_NUMBER);
      pend_emit  = pend_valid && (end_of_input || !(ident_cont || number_cont));

      tail_tok = '0;
      tail_tok.last = 1'b1;
      if (end_of_input) begin
         tail_tok.token_kind = TOKEN_END;
         tail_valid          = 1'b1;
      end else begin
         tail_tok.token_kind = TOKEN_CHAR;
         tail_tok.char_value = char_code;
         tail_valid = (mode_ff != MODE_COMMENT) && !ident_cont && !number_cont &&
                      !is_space && !is_alpha && !is_digit && (char_code != CHAR_HASH);
      end

      pend_tok.last = !tail_valid;
      lex_out.first  = pend_emit ? pend_tok : tail_tok;
      lex_out.second = tail_tok;
      lex_out.count  = 2'(pend_emit) + 2'(tail_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_IDLE;
         ident_bytes_ff  <= '0;
         ident_count_ff  <= '0;
         number_accum_ff <= '0;
         number_sat_ff   <= 1'b0;
      end else if (step) begin
         mode_ff         <= mode_in;
         ident_bytes_ff  <= ident_bytes_in;
         ident_count_ff  <= ident_count_in;
         number_accum_ff <= number_accum_in;
         number_sat_ff   <= number_sat_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/cst_rsp_queue.sv @@
`default_nettype none

module cst_rsp_queue #(
   parameter int RSP_DEPTH = cst_pkg::RSP_DEPTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire cst_pkg::lex_out_type  lex_out,
   output logic                       full,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output cst_pkg::lex_token_type     rsp_token
);
   import cst_pkg::*;

   `include "char_stream_tokenizer_core_assert.svh"

   localparam int PTR_W = (RSP_DEPTH > 1) ? $clog2(RSP_DEPTH) : 1;
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      ptr_inc = (p == PTR_W'(RSP_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   lex_token_type    q_ff [RSP_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [1:0]       push_n;
   logic             pop;
   logic [PTR_W-1:0] wr_next;

   always_comb begin
      push_n    = push ? lex_out.count : 2'd0;
      rsp_valid = (count_ff != '0);
      pop       = rsp_valid && !rsp_stall;
      // keep room for a two-token word
      full      = count_ff > CNT_W'(RSP_DEPTH - 2);
      wr_next   = ptr_inc(wr_ptr_ff);
      wr_ptr_in = wr_ptr_ff;
      if (push_n == 2'd1) begin
         wr_ptr_in = wr_next;
      end else if (push_n == 2'd2) begin
         wr_ptr_in = ptr_inc(wr_next);
      end
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push_n) - CNT_W'(pop);
      rsp_token = q_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         q_ff[wr_ptr_ff] <= lex_out.first;
      end
      if (push_n == 2'd2) begin
         q_ff[wr_next] <= lex_out.second;
      end
   end

   `CST_ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(RSP_DEPTH))
   `CST_ASSERT_IMPLIES(a_no_overrun, clock, reset, push_n != 2'd0,
      count_ff <= CNT_W'(RSP_DEPTH - 2))
   `CST_ASSERT_IMPLIES(a_last_order, clock, reset, push_n == 2'd2,
      !lex_out.first.last && lex_out.second.last)
   `CST_ASSERT_NEXT(a_pop_drains, clock, reset, pop && push_n == 2'd0,
      count_ff == $past(count_ff) - CNT_W'(1))

endmodule

`default_nettype wire

@@ rtl/char_stream_tokenizer_core.sv @@
// A word accepted by the core pushes its tokens, if any, into the result queue, which drives rsp_ from registers.
// Input: one word per cycle while req_stall is low; the lexer state update is a single registered step.
// Output drains one token per cycle while rsp_stall is low; a word that makes two tokens presents them in order.
// req_stall rises while the result queue holds fewer than two free slots.
// Reset (synchronous): lexer returns to between tokens, result queue empties.
`default_nettype none

module char_stream_tokenizer_core #(
   parameter int IDENT_BYTES_KEPT = cst_pkg::IDENT_BYTES_KEPT_DEFAULT,
   parameter int RSP_DEPTH        = cst_pkg::RSP_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_char_code,
   input  wire logic        req_end_of_input,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_token_kind,
   output logic [7:0]       rsp_char_value,
   output logic [30:0]      rsp_number_value,
   output logic             rsp_number_overflow,
   output logic [63:0]      rsp_ident_text,
   output logic [7:0]       rsp_ident_length,
   output logic             rsp_ident_truncated,
   output logic             rsp_last
);
   import cst_pkg::*;

   lex_out_type   lex_out;
   lex_token_type rsp_token;
   logic          step;
   logic          full;

   assign req_stall = full;
   assign step      = req_valid && !full;

   cst_lexer #(
      .IDENT_BYTES_KEPT(IDENT_BYTES_KEPT)
   ) u_lexer (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .char_code    (req_char_code),
      .end_of_input (req_end_of_input),
      .lex_out      (lex_out)
   );

   cst_rsp_queue #(
      .RSP_DEPTH(RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (step),
      .lex_out   (lex_out),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_token (rsp_token)
   );

   assign rsp_token_kind      = rsp_token.token_kind;
   assign rsp_char_value      = rsp_token.char_value;
   assign rsp_number_value    = rsp_token.number_value;
   assign rsp_number_overflow = rsp_token.number_overflow;
   assign rsp_ident_text      = rsp_token.ident_text;
   assign rsp_ident_length    = rsp_token.ident_length;
   assign rsp_ident_truncated = rsp_token.ident_truncated;
   assign rsp_last            = rsp_token.last;

endmodule

`default_nettype wire
